@@ rtl/ppf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants for the padded pixel fetch block.
// ----------------------------------------------------------------------------
package ppf_pkg;

    localparam int CFG_W   = 10;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 2;
    localparam int COORD_W = 17;
    localparam int PIXF_W  = 24;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + COORD_W;
    localparam int PIX_LSB    = COL_LSB + COORD_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_PADDING_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BLACK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WHITE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REFLECT = 2'd2;

    localparam logic [CFG_W-1:0]  HEIGHT_RESET = 10'd512;
    localparam logic [CFG_W-1:0]  WIDTH_RESET  = 10'd512;
    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_BLACK;

    typedef struct packed {
        logic load;
        logic coord_load;
        logic div_step;
        logic fold;
        logic addr_calc;
        logic mem_wr;
        logic mem_rd;
        logic out_load;
    } ppf_cmd_t;

    typedef struct packed {
        logic is_read;
        logic in_image;
        logic reflect;
        logic out_free;
    } ppf_status_t;

endpackage

@@ rtl/ppf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_datapath
// Config registers, request capture, bit-serial reflection remainders,
// address calculation, pixel store and output register.
// ----------------------------------------------------------------------------
module ppf_datapath
    import ppf_pkg::*;
#(
    parameter int MAX_HEIGHT   = 512,
    parameter int MAX_WIDTH    = 512,
    parameter int CHANNELS     = 3,
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                cmd,
    input  logic [COORD_W-1:0]  row,
    input  logic [COORD_W-1:0]  col,
    input  logic [PIXF_W-1:0]   pixel_in,
    input  ppf_cmd_t            ctrl_cmd,
    output ppf_status_t         status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PIXF_W-1:0]   pixel_out,
    output logic                was_padded
);

    localparam int PIX_W   = CHANNELS * CHANNEL_BITS;
    localparam int SW      = (PIX_W < PIXF_W) ? PIX_W : PIXF_W;
    localparam int DEPTH   = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RA_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CA_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MAX_DIM = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int PW      = $clog2(2 * MAX_DIM);

    function automatic logic [PW-1:0] rem_step(
        input logic [PW-1:0] rem,
        input logic          din,
        input logic [PW-1:0] period
    );
        logic [PW:0] t;
        t = {rem, din};
        if (t >= {1'b0, period})
            t = t - {1'b0, period};
        return t[PW-1:0];
    endfunction

    function automatic logic [31:0] fold_val(
        input logic [PW-1:0]    m,
        input logic [DIM_W-1:0] dim
    );
        logic [31:0] m32;
        logic [31:0] d32;
        m32 = 32'(m);
        d32 = 32'(dim);
        if (m32 > d32 - 32'd1)
            return 32'd2 * d32 - 32'd2 - m32;
        return m32;
    endfunction

    logic [CFG_W-1:0]   height_reg;
    logic [CFG_W-1:0]   width_reg;
    logic [MODE_W-1:0]  mode_reg;

    logic               cmd_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic [SW-1:0]      pix_reg;

    logic [COORD_W-1:0] ar_reg;
    logic [COORD_W-1:0] ac_reg;
    logic [PW-1:0]      rem_r_reg;
    logic [PW-1:0]      rem_c_reg;
    logic [RA_W-1:0]    rr_reg;
    logic [CA_W-1:0]    cc_reg;
    logic [AW-1:0]      addr_reg;
    logic [SW-1:0]      rdata_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIXF_W-1:0]  pixel_out_reg;
    logic               was_padded_reg;

    logic [SW-1:0]      pixel_store [DEPTH];

    logic [DIM_W-1:0]   h_eff;
    logic [DIM_W-1:0]   w_eff;
    logic [PW-1:0]      period_h;
    logic [PW-1:0]      period_w;
    logic               in_image;
    logic               reflect;
    logic [PIXF_W-1:0]  out_sel;

    always_comb
    begin
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(height_reg);

        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(width_reg);
    end

    assign period_h = PW'(32'd2 * 32'(h_eff) - 32'd1);
    assign period_w = PW'(32'd2 * 32'(w_eff) - 32'd1);

    assign in_image = !row_reg[COORD_W-1] && !col_reg[COORD_W-1]
                   && (32'(row_reg[COORD_W-2:0]) < 32'(h_eff))
                   && (32'(col_reg[COORD_W-2:0]) < 32'(w_eff));
    assign reflect  = (mode_reg != MODE_BLACK) && (mode_reg != MODE_WHITE);

    assign status.is_read  = (cmd_reg == CMD_READ);
    assign status.in_image = in_image;
    assign status.reflect  = reflect;
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
            width_reg  <= WIDTH_RESET;
            mode_reg   <= MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_PADDING_MODE: mode_reg   <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            cmd_reg <= cmd;
            row_reg <= row;
            col_reg <= col;
            pix_reg <= pixel_in[SW-1:0];
        end

        if (ctrl_cmd.coord_load)
        begin
            ar_reg    <= row_reg[COORD_W-1] ? COORD_W'(-row_reg) : row_reg;
            ac_reg    <= col_reg[COORD_W-1] ? COORD_W'(-col_reg) : col_reg;
            rem_r_reg <= '0;
            rem_c_reg <= '0;
            rr_reg    <= row_reg[RA_W-1:0];
            cc_reg    <= col_reg[CA_W-1:0];
        end
        else if (ctrl_cmd.div_step)
        begin
            rem_r_reg <= rem_step(rem_r_reg, ar_reg[COORD_W-1], period_h);
            rem_c_reg <= rem_step(rem_c_reg, ac_reg[COORD_W-1], period_w);
            ar_reg    <= {ar_reg[COORD_W-2:0], 1'b0};
            ac_reg    <= {ac_reg[COORD_W-2:0], 1'b0};
        end
        else if (ctrl_cmd.fold)
        begin
            rr_reg <= RA_W'(fold_val(rem_r_reg, h_eff));
            cc_reg <= CA_W'(fold_val(rem_c_reg, w_eff));
        end

        if (ctrl_cmd.addr_calc)
            addr_reg <= AW'(32'(rr_reg) * 32'(MAX_WIDTH) + 32'(cc_reg));
    end

    // pixel store, one port
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.mem_wr)
            pixel_store[addr_reg] <= pix_reg;
        if (ctrl_cmd.mem_rd)
            rdata_reg <= pixel_store[addr_reg];
    end

    always_comb
    begin
        if (in_image || reflect)
            out_sel = PIXF_W'(rdata_reg);
        else if (mode_reg == MODE_WHITE)
            out_sel = PIXF_W'({SW{1'b1}});
        else
            out_sel = '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl_cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.out_load)
        begin
            pixel_out_reg  <= out_sel;
            was_padded_reg <= !in_image;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign was_padded = was_padded_reg;

endmodule

@@ rtl/ppf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppf_ctrl
// Request sequencer: decode, remainder iterations, fold, address, store
// access and result hand-off.
// ----------------------------------------------------------------------------
module ppf_ctrl
    import ppf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ppf_status_t status,
    output ppf_cmd_t    ctrl_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_FOLD   = 3'd3;
    localparam logic [2:0] ST_ADDR   = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_SEND   = 3'd7;

    localparam int               CNT_W    = $clog2(COORD_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COORD_W - 1);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl_cmd   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl_cmd.load = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                ctrl_cmd.coord_load = 1'b1;
                cnt_next            = '0;
                if (status.in_image)
                    state_next = ST_ADDR;
                else if (!status.is_read)
                    state_next = ST_IDLE;
                else if (status.reflect)
                    state_next = ST_DIV;
                else
                    state_next = ST_SEND;
            end
            ST_DIV:
            begin
                ctrl_cmd.div_step = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                ctrl_cmd.fold = 1'b1;
                state_next    = ST_ADDR;
            end
            ST_ADDR:
            begin
                ctrl_cmd.addr_calc = 1'b1;
                state_next         = status.is_read ? ST_READ : ST_WRITE;
            end
            ST_WRITE:
            begin
                ctrl_cmd.mem_wr = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_READ:
            begin
                ctrl_cmd.mem_rd = 1'b1;
                state_next      = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    ctrl_cmd.out_load = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_wr_inside: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.mem_wr |-> (!status.is_read && status.in_image))
        else $error("store write for a read or outside request");

    a_div_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (status.is_read && status.reflect && !status.in_image))
        else $error("remainder iteration without a reflected read");

    a_fold_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> ($past(state_reg) == ST_DIV && $past(cnt_reg) == DIV_LAST))
        else $error("fold entered before all remainder steps");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending result");

endmodule

@@ rtl/padded_pixel_fetch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_pixel_fetch
// Single-image pixel store with black, white or reflect border handling
// on reads of signed coordinates.
// ----------------------------------------------------------------------------
// A read inside the image passes decode, address, store read and result load;
// a black or white border read goes from decode to result load; a reflected
// read adds 17 bit-serial remainder steps (row and column in parallel) and a
// fold before the address. One request at a time: a new one is taken after
// a write's store access, a dropped write's decode, or a read's result load.
// Reset clears control and config registers; the pixel store is not cleared.
// ----------------------------------------------------------------------------
module padded_pixel_fetch
    import ppf_pkg::*;
#(
    parameter int MAX_HEIGHT   = 512,
    parameter int MAX_WIDTH    = 512,
    parameter int CHANNELS     = 3,
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row[16:0], col[33:17], pixel_in[57:34]
    input  logic                  s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_out[23:0]
    output logic                  m_tuser    // was_padded
);

    ppf_cmd_t    ctrl_cmd;
    ppf_status_t status;

    assign cfg_ready = 1'b1;

    ppf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .ctrl_cmd (ctrl_cmd)
    );

    ppf_datapath #(
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNELS     (CHANNELS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (s_tuser),
        .row        (s_tdata[ROW_LSB +: COORD_W]),
        .col        (s_tdata[COL_LSB +: COORD_W]),
        .pixel_in   (s_tdata[PIX_LSB +: PIXF_W]),
        .ctrl_cmd   (ctrl_cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .pixel_out  (m_tdata),
        .was_padded (m_tuser)
    );

endmodule

@@ dv/padded_pixel_fetch_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_pixel_fetch_test
// Self-checking bench for the padded pixel fetch block. Pixel writes and
// padded reads go in over the slave stream and the border registers are set
// over the config channel between phases. A scoreboard keeps a shadow image
// and border settings, predicts every read result and checks it field by
// field. Phases cover black, white, reflect and the spare mode, dimension
// one, and size register values outside the legal range. The sender works in
// bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module padded_pixel_fetch_test;
    import ppf_pkg::*;

    localparam int MAX_H        = 512;
    localparam int MAX_W        = 512;
    localparam int DEPTH        = MAX_H * MAX_W;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 30;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASES       = 12;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [PIXF_W-1:0] WHITE_PIX  = 24'hffffff;

    typedef struct {
        logic [PIXF_W-1:0] pixel;
        logic              padded;
    } fetch_t;

    class pixel_fetch_board;
        logic [CFG_W-1:0]  height_raw;
        logic [CFG_W-1:0]  width_raw;
        logic [MODE_W-1:0] mode;
        logic [PIXF_W-1:0] pixels [int];
        fetch_t            expected_fetches [$];
        int                errors;

        function new();
            height_raw = HEIGHT_RESET;
            width_raw  = WIDTH_RESET;
            mode       = MODE_RESET;
            errors     = 0;
        endfunction

        function int dim_of(logic [CFG_W-1:0] raw, int maxv);
            if (raw == 0)
                return 1;
            return (int'(raw) > maxv) ? maxv : int'(raw);
        endfunction

        function int fold(int a, int dim);
            int period;
            int m;
            period = 2 * dim - 1;
            m = a % period;
            if (m > dim - 1)
                m = 2 * dim - 2 - m;
            return m;
        endfunction

        function void set_reg(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_IMAGE_HEIGHT: height_raw = data;
                REG_IMAGE_WIDTH:  width_raw  = data;
                REG_PADDING_MODE: mode       = data[MODE_W-1:0];
                default: ;
            endcase
        endfunction

        // where a request lands in the store, if it touches the store at all
        function void locate(input logic signed [COORD_W-1:0] row,
                             input logic signed [COORD_W-1:0] col,
                             output bit in_image, output bit from_store, output int addr);
            int h;
            int w;
            int r;
            int c;
            h = dim_of(height_raw, MAX_H);
            w = dim_of(width_raw, MAX_W);
            r = int'(row);
            c = int'(col);
            in_image = r >= 0 && c >= 0 && r < h && c < w;
            addr = 0;
            from_store = 1;
            if (in_image)
                addr = r * MAX_W + c;
            else if (mode == MODE_BLACK || mode == MODE_WHITE)
                from_store = 0;
            else
                addr = (fold(r < 0 ? -r : r, h) * MAX_W + fold(c < 0 ? -c : c, w)) % DEPTH;
        endfunction

        function bit take_request(logic cmd, logic signed [COORD_W-1:0] row,
                                  logic signed [COORD_W-1:0] col, logic [PIXF_W-1:0] pix);
            bit in_image;
            bit from_store;
            int addr;
            fetch_t f;
            locate(row, col, in_image, from_store, addr);
            if (cmd == CMD_WRITE) begin
                if (in_image)
                    pixels[addr] = pix;
                return in_image;
            end
            if (from_store)
                f.pixel = pixels[addr];
            else
                f.pixel = (mode == MODE_WHITE) ? WHITE_PIX : '0;
            f.padded = !in_image;
            expected_fetches.push_back(f);
            return 1;
        endfunction

        function void check_fetch(logic [PIXF_W-1:0] pix, logic padded);
            fetch_t f;
            if (expected_fetches.size() == 0) begin
                errors++;
                $display("%0t: unexpected result pixel=%h padded=%b", $time, pix, padded);
                return;
            end
            f = expected_fetches.pop_front();
            if (pix !== f.pixel) begin
                errors++;
                $display("%0t: pixel_out expected %h actual %h", $time, f.pixel, pix);
            end
            if (padded !== f.padded) begin
                errors++;
                $display("%0t: was_padded expected %b actual %b", $time, f.padded, padded);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [INDEX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    pixel_fetch_board board;
    int burst_left;
    int requests_sent;
    int cycles;
    int rx_tick;
    int rx_style;

    padded_pixel_fetch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: style changes now and then, from always ready to sparse
    always @(posedge clk)
    begin
        rx_tick++;
        if (rx_tick % 97 == 0)
            rx_style = $urandom_range(0, 2);
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (rx_tick % 4 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_fetch(m_tdata[PIXF_W-1:0], m_tuser);
    end

    task automatic send_request(input logic cmd, input logic signed [COORD_W-1:0] row,
                                input logic signed [COORD_W-1:0] col,
                                input logic [PIXF_W-1:0] pix);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_DATA_W - PIX_LSB - PIXF_W){1'b0}}, pix, col, row};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        if (board.take_request(cmd, row, col, pix))
            requests_sent++;
    endtask

    // a read whose source pixel was never stored gets that pixel stored first
    task automatic fetch_pixel(input logic signed [COORD_W-1:0] row,
                               input logic signed [COORD_W-1:0] col);
        bit in_image;
        bit from_store;
        int addr;
        board.locate(row, col, in_image, from_store, addr);
        if (from_store && !board.pixels.exists(addr))
            send_request(CMD_WRITE, COORD_W'(addr / MAX_W), COORD_W'(addr % MAX_W),
                         PIXF_W'($urandom));
        send_request(CMD_READ, row, col, PIXF_W'($urandom));
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.expected_fetches.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int pick_coord(int dim);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 7))
                    0: return -65536;
                    1: return 65535;
                    2: return -1;
                    3: return 0;
                    4: return dim - 1;
                    5: return dim;
                    6: return -dim;
                    default: return 2 * dim - 1;
                endcase
            end
            default: return int'($urandom_range(0, 4 * dim + 6)) - (2 * dim + 3);
        endcase
    endfunction

    int ph_height [PHASES] = '{4, 1, 0, 512, 7, 1023, 512, 2, 3, 512, 16, 9};
    int ph_width  [PHASES] = '{4, 1, 1023, 512, 13, 0, 512, 3, 1, 5, 16, 512};
    logic [MODE_W-1:0] ph_mode [PHASES] = '{MODE_REFLECT, MODE_REFLECT, MODE_SPARE,
        MODE_WHITE, MODE_BLACK, MODE_REFLECT, MODE_REFLECT, MODE_WHITE, MODE_REFLECT,
        MODE_SPARE, MODE_BLACK, MODE_REFLECT};

    initial
    begin
        int h;
        int w;
        int goal;
        bit in_image;
        bit from_store;
        int addr;
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col;

        board = new();
        burst_left = 0;
        requests_sent = 0;
        cycles = 0;
        rx_tick = 0;
        rx_style = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        m_tready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full 512 x 512 image, black border
        send_request(CMD_WRITE, 0, 0, 24'h000000);
        send_request(CMD_WRITE, 0, 511, 24'hffffff);
        send_request(CMD_WRITE, 511, 0, 24'ha5a5a5);
        send_request(CMD_WRITE, 511, 511, 24'h5a5a5a);
        send_request(CMD_WRITE, 1, 1, 24'h123456);
        send_request(CMD_WRITE, 512, 0, 24'hdeadbe);
        send_request(CMD_WRITE, -1, 3, 24'hbeef01);
        send_request(CMD_WRITE, 0, -65536, 24'h777777);
        fetch_pixel(0, 0);
        fetch_pixel(0, 511);
        fetch_pixel(511, 0);
        fetch_pixel(511, 511);
        fetch_pixel(1, 1);
        fetch_pixel(-1, 0);
        fetch_pixel(0, -1);
        fetch_pixel(512, 511);
        fetch_pixel(511, 512);
        fetch_pixel(-65536, -65536);
        fetch_pixel(65535, 65535);
        fetch_pixel(-65536, 65535);
        fetch_pixel(3, -1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_IMAGE_HEIGHT, CFG_W'(ph_height[p]));
            write_reg(REG_IMAGE_WIDTH, CFG_W'(ph_width[p]));
            write_reg(REG_PADDING_MODE, CFG_W'(ph_mode[p]));
            h = board.dim_of(board.height_raw, MAX_H);
            w = board.dim_of(board.width_raw, MAX_W);
            goal = requests_sent + RANDOM_ITEMS / PHASES;
            while (requests_sent < goal)
            begin
                if ($urandom_range(0, 99) < 40)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        row = COORD_W'(pick_coord(h));
                        col = COORD_W'(pick_coord(w));
                    end
                    else
                    begin
                        row = COORD_W'($urandom_range(0, h - 1));
                        col = COORD_W'($urandom_range(0, w - 1));
                    end
                    send_request(CMD_WRITE, row, col, PIXF_W'($urandom));
                end
                else
                begin
                    row = COORD_W'(pick_coord(h));
                    col = COORD_W'(pick_coord(w));
                    fetch_pixel(row, col);
                end
            end
            drain();
        end

        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
